### rtl/tlnf_pkg.sv
// Shared constants, codes and types of the text line number filter.
`default_nettype none

package tlnf_pkg;

    localparam int ND_DEFAULT  = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_ALL       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CARET_SHIFT = 8'h40;

    localparam logic [1:0] RUN_MAX = 2'd3;

    typedef struct packed {
        logic       number;
        logic       caret;
        logic       dollar;
        logic [7:0] ch;
    } tlnf_job_t;

endpackage

`default_nettype wire

### rtl/tlnf_ifs.sv
// Valid/ready channel interfaces for input bytes and output characters.
`default_nettype none

interface tlnf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_start;

    modport source (output valid, output in_byte, output file_start, input ready);
    modport sink (input valid, input in_byte, input file_start, output ready);
endinterface

interface tlnf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

### rtl/tlnf_front.sv
// Front end: option registers, line state and classification of each input byte.
`default_nettype none

module tlnf_front
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = ND_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    tlnf_in_if.sink                         in_ch,
    input  wire logic                       full,
    output logic                            push,
    output tlnf_job_t                       job_flags,
    output logic [4*NUMBER_DIGITS-1:0]      job_digits
);

    localparam int BCD_W = 4 * NUMBER_DIGITS;

    logic number_all_reg;
    logic number_nonblank_reg;
    logic squeeze_blank_reg;
    logic show_tabs_reg;
    logic show_ends_reg;
    logic show_nonprinting_reg;

    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic             start_reg;
    logic             start_next;
    logic [1:0]       run_reg;
    logic [1:0]       run_next;

    logic [BCD_W-1:0]       bcd_base;
    logic [BCD_W-1:0]       bcd_inc;
    logic [NUMBER_DIGITS:0] nines_below;
    logic                   start_base;
    logic [1:0]             run_base;
    logic                   accept;
    logic                   do_number;
    logic [7:0]             c;
    logic                   is_nl;
    logic                   is_ctrl;
    logic                   tab_hit;
    logic                   ctrl_hit;
    logic                   del_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_all_reg       <= 1'b0;
            number_nonblank_reg  <= 1'b0;
            squeeze_blank_reg    <= 1'b0;
            show_tabs_reg        <= 1'b0;
            show_ends_reg        <= 1'b0;
            show_nonprinting_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUMBER_ALL:       number_all_reg       <= cfg_data[0];
                CFG_NUMBER_NONBLANK:  number_nonblank_reg  <= cfg_data[0];
                CFG_SQUEEZE_BLANK:    squeeze_blank_reg    <= cfg_data[0];
                CFG_SHOW_TABS:        show_tabs_reg        <= cfg_data[0];
                CFG_SHOW_ENDS:        show_ends_reg        <= cfg_data[0];
                CFG_SHOW_NONPRINTING: show_nonprinting_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;
    assign c           = in_ch.in_byte;
    assign is_nl       = (c == CH_NEWLINE);

    always_comb
    begin
        if (in_ch.file_start)
        begin
            bcd_base   = BCD_W'(1);
            start_base = 1'b1;
            run_base   = 2'd1;
        end
        else
        begin
            bcd_base   = bcd_reg;
            start_base = start_reg;
            run_base   = run_reg;
        end
    end

    always_comb
    begin
        nines_below[0] = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            nines_below[i+1] = nines_below[i] && (bcd_base[4*i +: 4] == 4'd9);
            if (!nines_below[i])
                bcd_inc[4*i +: 4] = bcd_base[4*i +: 4];
            else if (bcd_base[4*i +: 4] == 4'd9)
                bcd_inc[4*i +: 4] = 4'd0;
            else
                bcd_inc[4*i +: 4] = bcd_base[4*i +: 4] + 4'd1;
        end
    end

    always_comb
    begin
        if (squeeze_blank_reg && is_nl)
            run_next = (run_base < RUN_MAX) ? run_base + 2'd1 : RUN_MAX;
        else
            run_next = 2'd0;

        if (number_nonblank_reg)
            do_number = start_base && !is_nl;
        else
            do_number = number_all_reg && start_base && (run_next < RUN_MAX);

        is_ctrl  = (c <= CH_BS) || ((c >= CH_VT) && (c <= CH_CTRL_MAX));
        tab_hit  = show_tabs_reg && (c == CH_TAB);
        ctrl_hit = show_nonprinting_reg && is_ctrl;
        del_hit  = show_nonprinting_reg && (c == CH_DEL);

        job_flags.number = do_number;
        job_flags.caret  = tab_hit || ctrl_hit || del_hit;
        if (tab_hit)
            job_flags.ch = CH_I;
        else if (ctrl_hit)
            job_flags.ch = c + CARET_SHIFT;
        else if (del_hit)
            job_flags.ch = CH_QUESTION;
        else
            job_flags.ch = c;
        job_flags.dollar = show_ends_reg && is_nl;
        job_digits       = bcd_base;

        push = accept && (run_next < RUN_MAX);

        bcd_next   = (do_number && !nines_below[NUMBER_DIGITS]) ? bcd_inc : bcd_base;
        start_next = is_nl ? 1'b1 : (start_base && !do_number);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg   <= BCD_W'(1);
            start_reg <= 1'b1;
            run_reg   <= 2'd1;
        end
        else if (accept)
        begin
            bcd_reg   <= bcd_next;
            start_reg <= start_next;
            run_reg   <= run_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tlnf_fifo.sv
// Small register queue that decouples the front end from the output sequencer.
`default_nettype none

module tlnf_fifo
    import tlnf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign rdata      = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

### rtl/tlnf_back.sv
// Output sequencer: expands each queued job into characters through an output register.
`default_nettype none

module tlnf_back
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = ND_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       head_valid,
    input  wire tlnf_job_t                  head_flags,
    input  wire logic [4*NUMBER_DIGITS-1:0] head_digits,
    output logic                            pop,
    tlnf_out_if.source                      out_ch
);

    localparam int IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    localparam logic [2:0] PH_DIGIT  = 3'd0;
    localparam logic [2:0] PH_TAB    = 3'd1;
    localparam logic [2:0] PH_CARET  = 3'd2;
    localparam logic [2:0] PH_DOLLAR = 3'd3;
    localparam logic [2:0] PH_CHAR   = 3'd4;

    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             lead_reg;
    logic             lead_next;
    logic             started_reg;
    logic             started_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic [2:0]       cur_phase;
    logic [2:0]       after_tab;
    logic [2:0]       after_caret;
    logic [IDX_W-1:0] cur_idx;
    logic             cur_lead;
    logic [3:0]       digit;
    logic             blank;
    logic             out_load;
    logic             step;

    assign out_load = !out_valid_reg || out_ch.ready;
    assign step     = head_valid && out_load;

    always_comb
    begin
        after_caret = head_flags.dollar ? PH_DOLLAR : PH_CHAR;
        after_tab   = head_flags.caret ? PH_CARET : after_caret;

        if (started_reg)
            cur_phase = phase_reg;
        else if (head_flags.number)
            cur_phase = PH_DIGIT;
        else
            cur_phase = after_tab;

        cur_idx  = started_reg ? idx_reg : IDX_W'(NUMBER_DIGITS - 1);
        cur_lead = started_reg ? lead_reg : 1'b1;
        digit    = head_digits[4*cur_idx +: 4];
        blank    = cur_lead && (digit == 4'd0) && (cur_idx != '0);

        phase_next    = phase_reg;
        idx_next      = idx_reg;
        lead_next     = lead_reg;
        started_next  = started_reg;
        pop           = 1'b0;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg;

        if (out_load)
            out_valid_next = head_valid;

        if (step)
        begin
            started_next  = 1'b1;
            out_last_next = 1'b0;
            unique case (cur_phase)
                PH_DIGIT:
                begin
                    out_byte_next = blank ? CH_SPACE : CH_ZERO + {4'd0, digit};
                    lead_next     = blank;
                    idx_next      = cur_idx - 1'b1;
                    phase_next    = (cur_idx == '0) ? PH_TAB : PH_DIGIT;
                end
                PH_TAB:
                begin
                    out_byte_next = CH_TAB;
                    phase_next    = after_tab;
                end
                PH_CARET:
                begin
                    out_byte_next = CH_CARET;
                    phase_next    = after_caret;
                end
                PH_DOLLAR:
                begin
                    out_byte_next = CH_DOLLAR;
                    phase_next    = PH_CHAR;
                end
                PH_CHAR:
                begin
                    out_byte_next = head_flags.ch;
                    out_last_next = 1'b1;
                    started_next  = 1'b0;
                    pop           = 1'b1;
                end
                default:
                begin
                    started_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DIGIT;
            idx_reg       <= '0;
            lead_reg      <= 1'b1;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            lead_reg      <= lead_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.last     = out_last_reg;

endmodule

`default_nettype wire

### rtl/text_line_number_filter_core.sv
// Top level of the text line number filter: front end, job queue and output sequencer.
//
// Input channel in_ch carries one file byte per transaction with a file_start
// flag that restarts line numbering and line state before that byte. Output
// channel out_ch carries one character per transaction; last marks the final
// character produced by an input byte. A byte that is a squeezed blank line
// produces no output transaction at all.
// Options are written through cfg_we/cfg_index/cfg_data (bit 0 used) while idle.
// An input byte passes through the job queue and then the output register.
// The output sequencer emits one character per cycle while out_ch.ready is high,
// so a byte that yields one character sustains one byte per cycle; a numbered
// line start yields NUMBER_DIGITS + 2 or NUMBER_DIGITS + 3 characters.
// A four-entry job queue lets the input run ahead while the output stalls;
// when the receiver holds ready low the output register holds its character
// and in_ch.ready drops once the queue fills.
// Reset clears all options, sets the line number to one and empties the queue.
`default_nettype none

module text_line_number_filter_core
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = ND_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    tlnf_in_if.sink                     in_ch,
    tlnf_out_if.source                  out_ch
);

    localparam int DIG_W = 4 * NUMBER_DIGITS;
    localparam int JOB_W = $bits(tlnf_job_t) + DIG_W;

    logic             full;
    logic             push;
    logic             pop;
    logic             head_valid;
    tlnf_job_t        job_flags;
    logic [DIG_W-1:0] job_digits;
    tlnf_job_t        head_flags;
    logic [DIG_W-1:0] head_digits;
    logic [JOB_W-1:0] head_word;

    tlnf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .full       (full),
        .push       (push),
        .job_flags  (job_flags),
        .job_digits (job_digits)
    );

    tlnf_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wdata      ({job_flags, job_digits}),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .rdata      (head_word)
    );

    assign head_flags  = head_word[JOB_W-1:DIG_W];
    assign head_digits = head_word[DIG_W-1:0];

    tlnf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_flags  (head_flags),
        .head_digits (head_digits),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the cat-style text line number filter core.
`timescale 1ns / 100ps

module tb;
    import tlnf_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int ND            = ND_DEFAULT;
    localparam int NUM_OPTS      = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int RAND_PHASES   = 4;
    localparam int PHASE_ITEMS   = 80;
    localparam int COUNT_ITEMS   = 130;
    localparam int MAX_PRINTED   = 100;

    localparam logic [NUM_OPTS-1:0] OPT_NONE     = '0;
    localparam logic [NUM_OPTS-1:0] OPT_NUM      = 6'b1 << CFG_NUMBER_ALL;
    localparam logic [NUM_OPTS-1:0] OPT_NONBLANK = 6'b1 << CFG_NUMBER_NONBLANK;
    localparam logic [NUM_OPTS-1:0] OPT_SQUEEZE  = 6'b1 << CFG_SQUEEZE_BLANK;
    localparam logic [NUM_OPTS-1:0] OPT_TABS     = 6'b1 << CFG_SHOW_TABS;
    localparam logic [NUM_OPTS-1:0] OPT_ENDS     = 6'b1 << CFG_SHOW_ENDS;
    localparam logic [NUM_OPTS-1:0] OPT_NONPRINT = 6'b1 << CFG_SHOW_NONPRINTING;
    localparam logic [NUM_OPTS-1:0] OPT_ALL      =
        OPT_NUM | OPT_NONBLANK | OPT_SQUEEZE | OPT_TABS | OPT_ENDS | OPT_NONPRINT;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_char_t;

    typedef struct packed {
        logic [NUM_OPTS-1:0] opts;
        logic [7:0]          ch;
        logic                fs;
        logic                typed;
        logic [3:0]          n;
        logic [79:0]         text;
    } row_t;

    localparam int N_ROWS = 26;
    localparam row_t DIRECTED [0:N_ROWS-1] = '{
        '{OPT_NONE,     "A",    1'b0, 1'b1, 4'd1, "A"},
        '{OPT_NONE,     8'hFF,  1'b0, 1'b1, 4'd1, 80'hFF},
        '{OPT_NONE,     8'h00,  1'b0, 1'b1, 4'd1, 80'h00},
        '{OPT_NONE,     "\n",   1'b0, 1'b1, 4'd1, "\n"},
        '{OPT_NONPRINT, 8'h00,  1'b0, 1'b1, 4'd2, "^@"},
        '{OPT_NONPRINT, 8'h1F,  1'b0, 1'b1, 4'd2, "^_"},
        '{OPT_NONPRINT, 8'h7F,  1'b0, 1'b1, 4'd2, "^?"},
        '{OPT_NONPRINT, 8'h80,  1'b0, 1'b1, 4'd1, 80'h80},
        '{OPT_NONPRINT, "\t",   1'b0, 1'b1, 4'd1, "\t"},
        '{OPT_NONPRINT, 8'h0B,  1'b0, 1'b1, 4'd2, "^K"},
        '{OPT_TABS,     "\t",   1'b0, 1'b1, 4'd2, "^I"},
        '{OPT_TABS,     8'h01,  1'b0, 1'b1, 4'd1, 80'h01},
        '{OPT_ENDS,     "\n",   1'b0, 1'b1, 4'd2, "$\n"},
        '{OPT_NUM,      "a",    1'b1, 1'b1, 4'd8, "     1\ta"},
        '{OPT_NUM,      "\n",   1'b0, 1'b1, 4'd1, "\n"},
        '{OPT_NUM,      "\n",   1'b0, 1'b1, 4'd8, "     2\t\n"},
        '{OPT_NONBLANK, "b",    1'b1, 1'b1, 4'd8, "     1\tb"},
        '{OPT_NONBLANK, "\n",   1'b0, 1'b1, 4'd1, "\n"},
        '{OPT_NONBLANK, "\n",   1'b0, 1'b1, 4'd1, "\n"},
        '{OPT_NONBLANK, "c",    1'b0, 1'b0, 4'd0, 80'h0},
        '{OPT_SQUEEZE,  "\n",   1'b1, 1'b1, 4'd1, "\n"},
        '{OPT_SQUEEZE,  "\n",   1'b0, 1'b1, 4'd0, 80'h0},
        '{OPT_SQUEEZE,  "\n",   1'b0, 1'b1, 4'd0, 80'h0},
        '{OPT_ALL,      "\t",   1'b1, 1'b0, 4'd0, 80'h0},
        '{OPT_ALL,      "\n",   1'b0, 1'b0, 4'd0, 80'h0},
        '{OPT_ALL,      8'h7F,  1'b0, 1'b0, 4'd0, 80'h0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tlnf_in_if  in_ch();
    tlnf_out_if out_ch();

    text_line_number_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    logic [NUM_OPTS-1:0] opts;
    logic [4*ND-1:0]     line_bcd;
    logic                at_start;
    logic [1:0]          nl_run;

    out_char_t pending_chars[$];
    out_char_t produced[$];
    out_char_t head_char;
    int        errors;
    int        stall_cycles;
    bit        steady;

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
        out_ch.ready <= steady || ($urandom_range(99) >= 34);

    task automatic report(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Filter one byte through the line state, leaving its characters in produced.
    function automatic void filter_byte(input logic [7:0] b, input logic fs);
        logic [7:0]      c;
        logic            numbered;
        logic            lead;
        logic            carry;
        logic [4*ND-1:0] nxt;
        out_char_t       oc;

        produced.delete();
        oc.last = 1'b0;
        c = b;
        if (fs)
        begin
            line_bcd = (4*ND)'(1);
            at_start = 1'b1;
            nl_run   = 2'd1;
        end
        if (opts[CFG_SQUEEZE_BLANK] && c == CH_NEWLINE)
        begin
            if (nl_run < RUN_MAX)
                nl_run++;
        end
        else
            nl_run = 2'd0;

        if (opts[CFG_NUMBER_NONBLANK])
            numbered = at_start && c != CH_NEWLINE;
        else
            numbered = opts[CFG_NUMBER_ALL] && at_start && nl_run < RUN_MAX;

        if (numbered)
        begin
            lead = 1'b1;
            for (int i = ND - 1; i >= 0; i--)
            begin
                if (line_bcd[4*i +: 4] != 4'd0 || i == 0)
                    lead = 1'b0;
                oc.ch = lead ? CH_SPACE : CH_ZERO + {4'd0, line_bcd[4*i +: 4]};
                produced.push_back(oc);
            end
            oc.ch = CH_TAB;
            produced.push_back(oc);
            // advance the BCD line number, holding at all nines
            carry = 1'b1;
            nxt = line_bcd;
            for (int i = 0; i < ND; i++)
            begin
                if (carry)
                begin
                    if (line_bcd[4*i +: 4] >= 4'd9)
                        nxt[4*i +: 4] = 4'd0;
                    else
                    begin
                        nxt[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                        carry = 1'b0;
                    end
                end
            end
            if (!carry)
                line_bcd = nxt;
            at_start = 1'b0;
        end

        oc.ch = CH_CARET;
        if (opts[CFG_SHOW_TABS] && c == CH_TAB)
        begin
            produced.push_back(oc);
            c = CH_I;
        end
        if (opts[CFG_SHOW_NONPRINTING] && (c <= CH_BS || (c >= CH_VT && c <= CH_CTRL_MAX)))
        begin
            produced.push_back(oc);
            c = c + CARET_SHIFT;
        end
        if (opts[CFG_SHOW_NONPRINTING] && c == CH_DEL)
        begin
            produced.push_back(oc);
            c = c - CARET_SHIFT;
        end
        if (nl_run < RUN_MAX)
        begin
            if (opts[CFG_SHOW_ENDS] && c == CH_NEWLINE)
            begin
                oc.ch = CH_DOLLAR;
                produced.push_back(oc);
            end
            oc.ch = c;
            produced.push_back(oc);
        end
        if (c == CH_NEWLINE)
            at_start = 1'b1;
        if (produced.size() > 0)
            produced[produced.size()-1].last = 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fs, input logic typed,
                             input logic [3:0] n, input logic [79:0] text);
        out_char_t oc;

        if (!steady)
            while ($urandom_range(99) < 34)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.file_start <= fs;
        do
            @(posedge clk);
        while (!in_ch.ready);

        filter_byte(b, fs);
        if (typed)
        begin
            for (int i = 0; i < int'(n); i++)
            begin
                oc.ch   = text[8*(int'(n)-1-i) +: 8];
                oc.last = (i == int'(n) - 1);
                pending_chars.push_back(oc);
            end
        end
        else
            foreach (produced[i])
                pending_chars.push_back(produced[i]);
    endtask

    // Drain, then write every register index, out-of-range ones included.
    task automatic set_options(input logic [NUM_OPTS-1:0] o);
        in_ch.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < 2**CFG_INDEX_W; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= (i < NUM_OPTS) ? o[i] : CFG_DATA_W'($urandom_range(1));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        opts = o;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_chars.size() == 0)
                report($sformatf("unexpected char %h last %b", out_ch.out_byte, out_ch.last));
            else
            begin
                head_char = pending_chars.pop_front();
                if (out_ch.out_byte !== head_char.ch)
                    report($sformatf("out_byte %h, want %h", out_ch.out_byte, head_char.ch));
                if (out_ch.last !== head_char.last)
                    report($sformatf("last %b, want %b on char %h",
                                     out_ch.last, head_char.last, head_char.ch));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("text_line_number_filter_core regression: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [7:0] b;
        int         pick;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = '0;
        in_ch.file_start = 1'b0;
        out_ch.ready     = 1'b0;
        steady           = 1'b0;
        errors           = 0;
        stall_cycles     = 0;
        opts             = OPT_NONE;
        line_bcd         = (4*ND)'(1);
        at_start         = 1'b1;
        nl_run           = 2'd1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            if (r == 0 || DIRECTED[r].opts != opts)
                set_options(DIRECTED[r].opts);
            send_byte(DIRECTED[r].ch, DIRECTED[r].fs, DIRECTED[r].typed,
                      DIRECTED[r].n, DIRECTED[r].text);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_options(p == 0 ? OPT_ALL : p == 1 ? OPT_NONE : NUM_OPTS'($urandom_range(63)));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    b = CH_NEWLINE;
                else if (pick < 40)
                    b = CH_TAB;
                else if (pick < 55)
                    b = 8'($urandom_range(31));
                else if (pick < 60)
                    b = CH_DEL;
                else if (pick < 70)
                    b = 8'($urandom_range(255, 128));
                else
                    b = 8'($urandom_range(255));
                send_byte(b, $urandom_range(39) == 0, 1'b0, 4'd0, 80'h0);
            end
        end

        // run the line counter through its decimal carries without gaps
        steady = 1'b1;
        set_options(OPT_NUM | OPT_ENDS);
        for (int k = 0; k < COUNT_ITEMS; k++)
        begin
            b = ($urandom_range(19) == 0) ? 8'($urandom_range(126, 33)) : CH_NEWLINE;
            send_byte(b, k == 0, 1'b0, 4'd0, 80'h0);
        end
        steady = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("text_line_number_filter_core regression: pass");
        else
            $display("text_line_number_filter_core regression: fail");
        $finish;
    end

endmodule
